### design/sclt_pkg.sv
// Package for the shell command line tokenizer: scan modes, token kinds,
// character codes and the per-byte lexing functions. No dependencies.
`default_nettype none

package sclt_pkg;

    localparam int MAX_WORD    = 1024;
    localparam int WL_W        = $clog2(MAX_WORD);
    localparam int MAX_RES     = 4;
    localparam int FEED_PASSES = 3;

    localparam logic [WL_W-1:0] WORD_LIMIT = WL_W'(MAX_WORD - 1);

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;

    typedef enum logic [7:0] {
        M_START = 8'b0000_0001,
        M_WORD  = 8'b0000_0010,
        M_DQ    = 8'b0000_0100,
        M_SQ    = 8'b0000_1000,
        M_ESCP  = 8'b0001_0000,
        M_ESCD  = 8'b0010_0000,
        M_PEND  = 8'b0100_0000,
        M_CMT   = 8'b1000_0000
    } t_mode;

    typedef enum logic [3:0] {
        K_BYTE = 4'd0,
        K_WEND = 4'd1,
        K_PIPE = 4'd2,
        K_IN   = 4'd3,
        K_OUT  = 4'd4,
        K_APP  = 4'd5,
        K_ERR  = 4'd6,
        K_BOTH = 4'd7,
        K_BG   = 4'd8,
        K_AND  = 4'd9,
        K_OR   = 4'd10,
        K_SEMI = 4'd11,
        K_EOL  = 4'd12
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_res;

    // Working state of the lexer while one item is processed.
    typedef struct packed {
        t_mode                  mode;
        logic [7:0]             pend;
        logic [WL_W-1:0]        wl;
        logic [2:0]             n;
        t_res [MAX_RES-1:0]     res;
        logic                   again;
    } t_lex;

    // Appends a result; results past the fourth are dropped.
    function automatic t_lex lex_put(t_lex s, t_kind k, logic [7:0] c);
        t_lex r;
        r = s;
        if (s.n < 3'(MAX_RES)) begin
            r.res[s.n[1:0]].kind = k;
            r.res[s.n[1:0]].ch   = (k == K_BYTE) ? c : 8'h00;
            r.n = s.n + 3'd1;
        end
        return r;
    endfunction

    // Emits a word byte and closes the word once it reaches the limit.
    function automatic t_lex lex_add(t_lex s, logic [7:0] c);
        t_lex r;
        r = lex_put(s, K_BYTE, c);
        r.wl = s.wl + WL_W'(1);
        if (r.wl >= WORD_LIMIT) begin
            r = lex_put(r, K_WEND, 8'h00);
            r.mode = M_START;
            r.wl = '0;
        end
        return r;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // One dispatch of a byte in the current mode. Sets again when the same
    // byte must be looked at once more in the new mode.
    function automatic t_lex lex_feed(t_lex s, logic [7:0] c);
        t_lex r;
        r = s;
        r.again = 1'b0;
        unique case (s.mode)
            M_START: begin
                if (!is_blank(c)) begin
                    case (c) inside
                        CH_HASH: r.mode = M_CMT;
                        CH_PIPE, CH_AMP, CH_GT, CH_TWO: begin
                            r.mode = M_PEND;
                            r.pend = c;
                        end
                        CH_LT:   r = lex_put(r, K_IN, 8'h00);
                        CH_SEMI: r = lex_put(r, K_SEMI, 8'h00);
                        default: begin
                            r.mode  = M_WORD;
                            r.wl    = '0;
                            r.again = 1'b1;
                        end
                    endcase
                end
            end
            M_WORD: begin
                if (is_blank(c)) begin
                    r = lex_put(r, K_WEND, 8'h00);
                    r.mode = M_START;
                    r.wl = '0;
                end else begin
                    case (c) inside
                        CH_PIPE, CH_GT, CH_LT, CH_AMP, CH_SEMI, CH_HASH: begin
                            r = lex_put(r, K_WEND, 8'h00);
                            r.mode  = M_START;
                            r.wl    = '0;
                            r.again = 1'b1;
                        end
                        CH_DQUOTE: r.mode = M_DQ;
                        CH_SQUOTE: r.mode = M_SQ;
                        CH_BSLASH: r.mode = M_ESCP;
                        default:   r = lex_add(r, c);
                    endcase
                end
            end
            M_DQ: begin
                if (c == CH_DQUOTE) begin
                    r.mode = M_WORD;
                end else if (c == CH_BSLASH) begin
                    r.mode = M_ESCD;
                end else begin
                    r = lex_add(r, c);
                end
            end
            M_SQ: begin
                if (c == CH_SQUOTE) begin
                    r.mode = M_WORD;
                end else begin
                    r = lex_add(r, c);
                end
            end
            M_ESCP: begin
                r.mode = M_WORD;
                r = lex_add(r, c);
            end
            M_ESCD: begin
                r.mode = M_DQ;
                r = lex_add(r, c);
            end
            M_PEND: begin
                r.pend = 8'h00;
                r.mode = M_START;
                if (s.pend == CH_PIPE && c == CH_PIPE) begin
                    r = lex_put(r, K_OR, 8'h00);
                end else if (s.pend == CH_AMP && c == CH_AMP) begin
                    r = lex_put(r, K_AND, 8'h00);
                end else if (s.pend == CH_AMP && c == CH_GT) begin
                    r = lex_put(r, K_BOTH, 8'h00);
                end else if (s.pend == CH_GT && c == CH_GT) begin
                    r = lex_put(r, K_APP, 8'h00);
                end else if (s.pend == CH_TWO) begin
                    if (c == CH_GT) begin
                        r = lex_put(r, K_ERR, 8'h00);
                    end else begin
                        // A held 2 that is not a redirection opens a word.
                        r.mode = M_WORD;
                        r.wl = '0;
                        r = lex_add(r, CH_TWO);
                        r.again = 1'b1;
                    end
                end else begin
                    if (s.pend == CH_PIPE) begin
                        r = lex_put(r, K_PIPE, 8'h00);
                    end else if (s.pend == CH_AMP) begin
                        r = lex_put(r, K_BG, 8'h00);
                    end else begin
                        r = lex_put(r, K_OUT, 8'h00);
                    end
                    r.again = 1'b1;
                end
            end
            M_CMT: ;
            default: ;
        endcase
        return r;
    endfunction

    // Closes whatever is open at the end of a line and returns to reset.
    function automatic t_lex lex_flush(t_lex s);
        t_lex r;
        r = s;
        unique case (s.mode)
            M_WORD, M_DQ, M_SQ: r = lex_put(r, K_WEND, 8'h00);
            M_ESCP, M_ESCD: begin
                r.mode = M_WORD;
                r = lex_add(r, CH_BSLASH);
                if (r.mode != M_START) r = lex_put(r, K_WEND, 8'h00);
            end
            M_PEND: begin
                if (s.pend == CH_TWO) begin
                    r.mode = M_WORD;
                    r.wl = '0;
                    r = lex_add(r, CH_TWO);
                    if (r.mode != M_START) r = lex_put(r, K_WEND, 8'h00);
                end else if (s.pend == CH_PIPE) begin
                    r = lex_put(r, K_PIPE, 8'h00);
                end else if (s.pend == CH_AMP) begin
                    r = lex_put(r, K_BG, 8'h00);
                end else begin
                    r = lex_put(r, K_OUT, 8'h00);
                end
            end
            M_START, M_CMT: ;
            default: ;
        endcase
        r = lex_put(r, K_EOL, 8'h00);
        r.mode = M_START;
        r.pend = 8'h00;
        r.wl = '0;
        return r;
    endfunction

endpackage

`default_nettype wire

### design/sclt_if.sv
// Handshake interfaces for the tokenizer's byte input and token output.
// Depends on sclt_pkg for the token kind type.
`default_nettype none

interface sclt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       has_char;
    logic       line_end;

    modport source (output valid, output char_in, output has_char, output line_end,
                    input ready);
    modport sink   (input valid, input char_in, input has_char, input line_end,
                    output ready);
endinterface

interface sclt_out_if;
    import sclt_pkg::*;
    logic       valid;
    logic       ready;
    t_kind      token_kind;
    logic [7:0] word_char;
    logic       last_of_run;

    modport source (output valid, output token_kind, output word_char,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input word_char,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

### design/shell_command_line_tokenizer.sv
// Streaming shell tokenizer: one command-line byte per input transfer,
// up to four tokens per byte from a result buffer, one per cycle while ready.
// Latency: the first token of a byte is offered the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one token and
// the output is ready; more tokens hold the input while the buffer drains.
// Reset (synchronous, active low) empties the buffer and returns to token start.
`default_nettype none

module shell_command_line_tokenizer (
    input  wire          i_clk,
    input  wire          i_rst_n,
    sclt_in_if.sink      i_in,
    sclt_out_if.source   o_out
);
    import sclt_pkg::*;

    // Lexer state that carries from one byte to the next.
    t_mode           r_mode;
    logic [7:0]      r_pend;
    logic [WL_W-1:0] r_wl;

    // Result buffer: the tokens of the last accepted byte, read in order.
    t_res            r_q [MAX_RES];
    logic [2:0]      r_cnt;
    logic [1:0]      r_rd;

    t_lex            n_lex;
    logic            in_xfer;
    logic            out_xfer;

    // A new byte is taken when the buffer is empty or its last token leaves
    // in this cycle, so results of two bytes never mix in the buffer.
    assign i_in.ready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = o_out.valid && o_out.ready;

    // The byte is dispatched up to three times: a held operator can hand
    // the byte back to token start, which in turn can open a word with it.
    always_comb begin
        n_lex.mode  = r_mode;
        n_lex.pend  = r_pend;
        n_lex.wl    = r_wl;
        n_lex.n     = 3'd0;
        n_lex.res   = '0;
        n_lex.again = i_in.has_char;
        for (int i = 0; i < FEED_PASSES; i++) begin
            if (n_lex.again) n_lex = lex_feed(n_lex, i_in.char_in);
        end
        if (i_in.line_end) n_lex = lex_flush(n_lex);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_pend <= 8'h00;
            r_wl   <= '0;
            r_cnt  <= 3'd0;
            r_rd   <= 2'd0;
        end else if (in_xfer) begin
            r_mode <= n_lex.mode;
            r_pend <= n_lex.pend;
            r_wl   <= n_lex.wl;
            r_cnt  <= n_lex.n;
            r_rd   <= 2'd0;
        end else if (out_xfer) begin
            r_cnt  <= r_cnt - 3'd1;
            r_rd   <= r_rd + 2'd1;
        end
    end

    // Token payloads need no reset; the count guards them.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_q[i] <= n_lex.res[i];
            end
        end
    end

    assign o_out.valid       = (r_cnt != 3'd0);
    assign o_out.token_kind  = r_q[r_rd].kind;
    assign o_out.word_char   = r_q[r_rd].ch;
    assign o_out.last_of_run = (r_cnt == 3'd1);

endmodule

`default_nettype wire

### design/sclt_checker.sv
// Port-level checks for the shell tokenizer and the bind that attaches them.
// Depends on sclt_pkg for token kinds.
`default_nettype none

module sclt_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       i_ready,
    input wire [3:0] i_kind,
    input wire [7:0] i_char,
    input wire       i_last
);
    import sclt_pkg::*;

    // A stalled token keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_char)
                                && $stable(i_last))
        else $error("stalled token changed");

    // Only word bytes carry a character.
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind != K_BYTE) |-> (i_char == 8'h00))
        else $error("non-byte token carries a character");

    // Kinds stay within the defined set.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_kind <= K_EOL))
        else $error("undefined token kind");

    // End of line is always the final token of its byte.
    a_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == K_EOL) |-> i_last)
        else $error("end of line not last of run");

endmodule

bind shell_command_line_tokenizer sclt_checker u_sclt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.token_kind),
    .i_char  (o_out.word_char),
    .i_last  (o_out.last_of_run)
);

`default_nettype wire
